// ===== sv/utf8_decode_classify_assert.svh =====
// Assertion macros shared by the decoder RTL; they compile to nothing for synthesis.
`ifndef UTF8_DECODE_CLASSIFY_ASSERT_SVH
`define UTF8_DECODE_CLASSIFY_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising aclk edge outside of reset.
`define U8DC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("u8dc assertion failed");
// Checked on every rising aclk edge, reset included.
`define U8DC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error("u8dc assertion failed");
`else
`define U8DC_ASSERT(label, prop)
`define U8DC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== sv/u8dc_pkg.sv =====
// Package for the UTF-8 decoder: widths, code point bounds and shared types.
`default_nettype none

package u8dc_pkg;

    localparam int OFFSET_WIDTH_DEFAULT = 16;
    localparam int CODE_WIDTH           = 21;
    localparam int FLAG_COUNT           = 5;

    // lead byte boundaries and payload masks
    localparam logic [7:0] LEAD_ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD_TWO_MAX   = 8'hDF;
    localparam logic [7:0] LEAD_THREE_MAX = 8'hEF;
    localparam logic [7:0] MASK_TWO       = 8'h1F;
    localparam logic [7:0] MASK_THREE     = 8'h0F;
    localparam logic [7:0] MASK_FOUR      = 8'h07;
    localparam logic [7:0] MASK_CONT      = 8'h3F;

    // pending continuation counts
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_ONE   = 2'd1;
    localparam logic [1:0] PEND_TWO   = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    // code points
    localparam logic [CODE_WIDTH-1:0] CP_TAB    = 21'h00009;
    localparam logic [CODE_WIDTH-1:0] CP_LF     = 21'h0000A;
    localparam logic [CODE_WIDTH-1:0] CP_SPACE  = 21'h00020;
    localparam logic [CODE_WIDTH-1:0] CP_UPPER_LO = 21'h00041;
    localparam logic [CODE_WIDTH-1:0] CP_UPPER_HI = 21'h0005A;
    localparam logic [CODE_WIDTH-1:0] CP_LOWER_LO = 21'h00061;
    localparam logic [CODE_WIDTH-1:0] CP_LOWER_HI = 21'h0007A;
    localparam logic [CODE_WIDTH-1:0] CJK_EXT_A_LO = 21'h03400;
    localparam logic [CODE_WIDTH-1:0] CJK_EXT_A_HI = 21'h04DBF;
    localparam logic [CODE_WIDTH-1:0] CJK_BASE_LO  = 21'h04E00;
    localparam logic [CODE_WIDTH-1:0] CJK_BASE_HI  = 21'h09FFF;
    localparam logic [CODE_WIDTH-1:0] CJK_COMPAT_LO = 21'h0F900;
    localparam logic [CODE_WIDTH-1:0] CJK_COMPAT_HI = 21'h0FAFF;
    localparam logic [CODE_WIDTH-1:0] CJK_SIP_LO    = 21'h20000;
    localparam logic [CODE_WIDTH-1:0] CJK_SIP_HI    = 21'h2FA1F;
    localparam logic [CODE_WIDTH-1:0] RTL_MAIN_LO   = 21'h00590;
    localparam logic [CODE_WIDTH-1:0] RTL_MAIN_HI   = 21'h008FF;
    localparam logic [CODE_WIDTH-1:0] RTL_PRES_A_LO = 21'h0FB1D;
    localparam logic [CODE_WIDTH-1:0] RTL_PRES_A_HI = 21'h0FDFF;
    localparam logic [CODE_WIDTH-1:0] RTL_PRES_B_LO = 21'h0FE70;
    localparam logic [CODE_WIDTH-1:0] RTL_PRES_B_HI = 21'h0FEFF;

    // tag carried with a completed scalar from decode to classify
    typedef struct packed {
        logic truncated;
        logic last;
    } scalar_tag_t;

    // result flags; is_blank sits in the lowest bit
    typedef struct packed {
        logic truncated;
        logic mixed_direction;
        logic is_ideograph;
        logic is_line_feed;
        logic is_blank;
    } class_flags_t;

endpackage

`default_nettype wire

// ===== sv/u8dc_decode.sv =====
// Byte assembly stage: lead/continuation decoding, offsets, completed-scalar register.
`default_nettype none

`include "utf8_decode_classify_assert.svh"

module u8dc_decode #(
    parameter int OFFSET_WIDTH = u8dc_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          in_byte,
    input  wire logic                                in_last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [u8dc_pkg::CODE_WIDTH-1:0]          out_value,
    output logic [OFFSET_WIDTH-1:0]                  out_start,
    output logic [OFFSET_WIDTH-1:0]                  out_end,
    output u8dc_pkg::scalar_tag_t                    out_tag
);

    localparam int CW = u8dc_pkg::CODE_WIDTH;
    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {OFFSET_WIDTH{1'b1}};

    logic [CW-1:0]           acc_reg, acc_next;
    logic [1:0]              pend_reg, pend_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;
    logic [OFFSET_WIDTH-1:0] count_reg, count_next;

    logic                    valid_reg, valid_next;
    logic [CW-1:0]           value_reg;
    logic [OFFSET_WIDTH-1:0] sstart_reg, send_reg;
    u8dc_pkg::scalar_tag_t   tag_reg;

    logic accept;
    logic emit;

    assign accept   = in_valid && in_ready;
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        if (pend_reg == u8dc_pkg::PEND_NONE) begin
            start_next = count_reg;
            priority if (in_byte <= u8dc_pkg::LEAD_ASCII_MAX) begin
                acc_next  = CW'(in_byte);
                pend_next = u8dc_pkg::PEND_NONE;
            end else if (in_byte <= u8dc_pkg::LEAD_TWO_MAX) begin
                acc_next  = CW'(in_byte & u8dc_pkg::MASK_TWO);
                pend_next = u8dc_pkg::PEND_ONE;
            end else if (in_byte <= u8dc_pkg::LEAD_THREE_MAX) begin
                acc_next  = CW'(in_byte & u8dc_pkg::MASK_THREE);
                pend_next = u8dc_pkg::PEND_TWO;
            end else begin
                acc_next  = CW'(in_byte & u8dc_pkg::MASK_FOUR);
                pend_next = u8dc_pkg::PEND_THREE;
            end
        end else begin
            // no check that this is really a continuation byte
            acc_next  = {acc_reg[CW-7:0], in_byte[5:0] & u8dc_pkg::MASK_CONT[5:0]};
            pend_next = pend_reg - 2'd1;
        end
        count_next = (count_reg == OFFSET_MAX) ? count_reg : count_reg + 1'b1;
    end

    assign emit = (pend_next == u8dc_pkg::PEND_NONE) || in_last;

    // decoder state; end of text returns everything to the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            pend_reg  <= u8dc_pkg::PEND_NONE;
            start_reg <= '0;
            count_reg <= '0;
        end else if (accept) begin
            if (in_last) begin
                acc_reg   <= '0;
                pend_reg  <= u8dc_pkg::PEND_NONE;
                start_reg <= '0;
                count_reg <= '0;
            end else begin
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                start_reg <= start_next;
                count_reg <= count_next;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = emit;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            value_reg         <= acc_next;
            sstart_reg        <= start_next;
            send_reg          <= count_next;
            tag_reg.truncated <= (pend_next != u8dc_pkg::PEND_NONE);
            tag_reg.last      <= in_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_start = sstart_reg;
    assign out_end   = send_reg;
    assign out_tag   = tag_reg;

    `U8DC_ASSERT(a_last_resets_state, accept && in_last |=> count_reg == '0 && pend_reg == u8dc_pkg::PEND_NONE)
    `U8DC_ASSERT(a_ascii_lead_emits, accept && pend_reg == u8dc_pkg::PEND_NONE && !in_byte[7] |=> valid_reg)
    `U8DC_ASSERT(a_truncated_only_at_end, valid_reg && tag_reg.truncated |-> tag_reg.last)
    `U8DC_ASSERT(a_offsets_ordered, valid_reg |-> send_reg >= sstart_reg)

endmodule

`default_nettype wire

// ===== sv/u8dc_classify.sv =====
// Classification stage: class flags, paragraph direction tracking, result register.
`default_nettype none

`include "utf8_decode_classify_assert.svh"

module u8dc_classify #(
    parameter int OFFSET_WIDTH = u8dc_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [u8dc_pkg::CODE_WIDTH-1:0]     in_value,
    input  wire logic [OFFSET_WIDTH-1:0]             in_start,
    input  wire logic [OFFSET_WIDTH-1:0]             in_end,
    input  wire u8dc_pkg::scalar_tag_t               in_tag,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [u8dc_pkg::CODE_WIDTH-1:0]          out_value,
    output logic [OFFSET_WIDTH-1:0]                  out_start,
    output logic [OFFSET_WIDTH-1:0]                  out_end,
    output u8dc_pkg::class_flags_t                   out_flags,
    output logic                                     out_last
);

    localparam int CW = u8dc_pkg::CODE_WIDTH;

    logic                    ltr_reg, rtl_reg;
    logic                    valid_reg, valid_next;
    logic [CW-1:0]           value_reg;
    logic [OFFSET_WIDTH-1:0] start_reg, end_reg;
    u8dc_pkg::class_flags_t  flags_reg, flags_next;
    logic                    last_reg;

    logic load;
    logic ideo, rtl_hit, ltr_hit, lf;
    logic ltr_new, rtl_new;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        ideo = (in_value >= u8dc_pkg::CJK_EXT_A_LO  && in_value <= u8dc_pkg::CJK_EXT_A_HI)
            || (in_value >= u8dc_pkg::CJK_BASE_LO   && in_value <= u8dc_pkg::CJK_BASE_HI)
            || (in_value >= u8dc_pkg::CJK_COMPAT_LO && in_value <= u8dc_pkg::CJK_COMPAT_HI)
            || (in_value >= u8dc_pkg::CJK_SIP_LO    && in_value <= u8dc_pkg::CJK_SIP_HI);
        rtl_hit = (in_value >= u8dc_pkg::RTL_MAIN_LO   && in_value <= u8dc_pkg::RTL_MAIN_HI)
               || (in_value >= u8dc_pkg::RTL_PRES_A_LO && in_value <= u8dc_pkg::RTL_PRES_A_HI)
               || (in_value >= u8dc_pkg::RTL_PRES_B_LO && in_value <= u8dc_pkg::RTL_PRES_B_HI);
        ltr_hit = (in_value >= u8dc_pkg::CP_UPPER_LO && in_value <= u8dc_pkg::CP_UPPER_HI)
               || (in_value >= u8dc_pkg::CP_LOWER_LO && in_value <= u8dc_pkg::CP_LOWER_HI)
               || ideo;
        lf      = (in_value == u8dc_pkg::CP_LF);
        ltr_new = ltr_reg || ltr_hit;
        rtl_new = rtl_reg || rtl_hit;

        flags_next.is_blank        = (in_value == u8dc_pkg::CP_SPACE)
                                  || (in_value == u8dc_pkg::CP_TAB);
        flags_next.is_line_feed    = lf;
        flags_next.is_ideograph    = ideo;
        // first scalar at which both directions have been seen
        flags_next.mixed_direction = !lf && !(ltr_reg && rtl_reg) && ltr_new && rtl_new;
        flags_next.truncated       = in_tag.truncated;
    end

    // paragraph tracking, cleared by newline and by end of text
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ltr_reg <= 1'b0;
            rtl_reg <= 1'b0;
        end else if (load) begin
            if (lf || in_tag.last) begin
                ltr_reg <= 1'b0;
                rtl_reg <= 1'b0;
            end else begin
                ltr_reg <= ltr_new;
                rtl_reg <= rtl_new;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            value_reg <= in_value;
            start_reg <= in_start;
            end_reg   <= in_end;
            flags_reg <= flags_next;
            last_reg  <= in_tag.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;
    assign out_start = start_reg;
    assign out_end   = end_reg;
    assign out_flags = flags_reg;
    assign out_last  = last_reg;

    `U8DC_ASSERT(a_newline_never_mixed, valid_reg |-> !(flags_reg.mixed_direction && flags_reg.is_line_feed))
    `U8DC_ASSERT(a_newline_clears_dir, load && lf |=> !ltr_reg && !rtl_reg)
    `U8DC_ASSERT(a_ideograph_sets_ltr, load && ideo && !in_tag.last |=> ltr_reg)
    `U8DC_ASSERT(a_mixed_needs_both, load && flags_next.mixed_direction && !in_tag.last |=> ltr_reg && rtl_reg)

endmodule

`default_nettype wire

// ===== sv/utf8_decode_classify.sv =====
// Top level of the UTF-8 decoder with scalar classification and direction tracking.
//
// Input channel (s_axis_*): one UTF-8 byte per beat in s_axis_tdata; s_axis_tlast
// marks the last byte of a text. Bytes are not checked: a lead byte sets the number
// of bytes to follow and every later byte shifts its low six bits in.
// Result channel (m_axis_*): one beat per completed scalar, carrying the code value,
// the offset of its lead byte and the offset just past it (both saturate at
// 2^OFFSET_WIDTH - 1), plus class flags in m_axis_tuser. m_axis_tlast is set on the
// result caused by the last byte; a text that ends mid-sequence yields the partial
// value with the truncated flag, and the byte after it starts again at offset 0.
// Throughput: one byte per cycle while s_axis_tready is high; byte assembly and
// classification are each combinational ahead of their register. The decode register
// loads when the byte that completes a scalar is accepted, and the result register
// loads from it once it is free. Bytes that do not complete a scalar give no beat.
// Stalls: when m_axis_tready is low the result register holds; the decode register
// still takes one more completed scalar, then s_axis_tready drops until the sink
// drains. Intermediate bytes are taken freely while the decode register is empty.
// Reset (aresetn low, synchronous): both stages empty, offsets and direction
// tracking cleared.
`default_nettype none

module utf8_decode_classify #(
    parameter int OFFSET_WIDTH = u8dc_pkg::OFFSET_WIDTH_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  wire logic                s_axis_tlast,   // end_of_text
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // code_value, start_offset, end_offset, zero fill
    output logic [((u8dc_pkg::CODE_WIDTH + 2*OFFSET_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // is_blank, is_line_feed, is_ideograph, mixed_direction, truncated
    output logic [u8dc_pkg::FLAG_COUNT-1:0] m_axis_tuser,
    output logic                     m_axis_tlast    // final_scalar
);

    localparam int CW      = u8dc_pkg::CODE_WIDTH;
    localparam int TDATA_W = ((CW + 2*OFFSET_WIDTH + 7) / 8) * 8;

    // decode -> classify
    logic                    dec_valid, dec_ready;
    logic [CW-1:0]           dec_value;
    logic [OFFSET_WIDTH-1:0] dec_start, dec_end;
    u8dc_pkg::scalar_tag_t   dec_tag;

    // classify -> ports
    logic [CW-1:0]           res_value;
    logic [OFFSET_WIDTH-1:0] res_start, res_end;
    u8dc_pkg::class_flags_t  res_flags;

    u8dc_decode #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_value (dec_value),
        .out_start (dec_start),
        .out_end   (dec_end),
        .out_tag   (dec_tag)
    );

    u8dc_classify #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_value  (dec_value),
        .in_start  (dec_start),
        .in_end    (dec_end),
        .in_tag    (dec_tag),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (res_value),
        .out_start (res_start),
        .out_end   (res_end),
        .out_flags (res_flags),
        .out_last  (m_axis_tlast)
    );

    // pack result beat, code value in the low bits, zero fill on top
    assign m_axis_tdata = TDATA_W'({res_end, res_start, res_value});
    assign m_axis_tuser = res_flags;

endmodule

`default_nettype wire
